@@ sv/cbi_pkg.sv @@
`timescale 1ns / 1ps

package cbi_pkg;

    // Field widths of the words on the ports
    localparam int COORD_BITS     = 16;
    localparam int ROOT_FRAC_BITS = 16;
    localparam int QW             = 32;

    // Internal widths, all derived from the coordinate and fraction widths
    localparam int CW    = COORD_BITS + 4;     // A, B, C components
    localparam int KW    = 2 * CW;             // cross products a, b, c
    localparam int MW    = KW;                 // cross product magnitudes
    localparam int HW    = MW / 2;             // half of a magnitude
    localparam int DW    = 2 * MW + 4;         // discriminant magnitude
    localparam int SW    = DW / 2;             // square root
    localparam int RW    = SW + 3;             // square root remainder
    localparam int NMW   = SW + 1;             // numerator magnitude
    localparam int NSW   = NMW + 1;            // signed numerator
    localparam int NDW   = NMW + ROOT_FRAC_BITS; // scaled dividend
    localparam int DVW   = MW + 1;             // divisor 2|a|
    localparam int RDW   = MW + 2;             // divider remainder
    localparam int LANES = 3;

    localparam logic signed [QW-1:0] ROOT_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] ROOT_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_DEGEN   = 2'd2
    } root_kind_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] ctrl1_x;
        logic signed [COORD_BITS-1:0] ctrl1_y;
        logic signed [COORD_BITS-1:0] ctrl2_x;
        logic signed [COORD_BITS-1:0] ctrl2_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_word_t;

    typedef struct packed {
        logic signed [QW-1:0] root1_real;
        logic signed [QW-1:0] root1_imag;
        logic signed [QW-1:0] root2_real;
        logic signed [QW-1:0] root2_imag;
        logic [1:0]           root_kind;
    } out_word_t;

    // Word moving down the square root chain
    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [SW-1:0]        root;
        logic [DW-1:0]        rad;
        logic signed [KW-1:0] kb;
        logic                 ka_neg;
        logic [MW-1:0]        ka_mag;
        root_kind_t           kind;
    } sq_word_t;

    // Word moving down the divider chain, three lanes side by side
    typedef struct packed {
        logic [LANES-1:0][NDW-1:0] num;
        logic [LANES-1:0][RDW-1:0] rem;
        logic [LANES-1:0][QW-1:0]  quo;
        logic [LANES-1:0]          ovf;
        logic [LANES-1:0]          neg;
        logic [DVW-1:0]            dv;
        root_kind_t                kind;
    } div_word_t;

    // Apply sign to a quotient magnitude and clamp to the Q16.16 range
    function automatic logic signed [QW-1:0] sat_root(
        input logic [QW-1:0] q,
        input logic          ovf,
        input logic          neg
    );
        logic signed [QW-1:0] r;
        if (neg)
        begin
            if (ovf || (q[QW-1] && (q[QW-2:0] != '0)))
                r = ROOT_MIN;
            else
                r = $signed(-q);
        end
        else
        begin
            if (ovf || q[QW-1])
                r = ROOT_MAX;
            else
                r = $signed(q);
        end
        return r;
    endfunction

endpackage

@@ sv/cbi_front.sv @@
`timescale 1ns / 1ps

module cbi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  cbi_pkg::in_word_t up_word,
    output logic              down_valid,
    input  logic              down_ready,
    output cbi_pkg::sq_word_t down_word
);
    import cbi_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] v_reg;
    logic [NST:0]   ld;

    // stage 1: curve coefficients
    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [CW-1:0] ax_next, ay_next, bx_next, by_next, cx_next, cy_next;
    // stage 2: products
    logic signed [KW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // stage 3: cross products
    logic signed [KW-1:0] ka_reg, kb3_reg, kc_reg;
    // stage 4: magnitudes and signs
    logic [MW-1:0]        ka_mag4_reg, kb_mag_reg, kc_mag_reg;
    logic signed [KW-1:0] kb4_reg;
    logic                 ka_neg4_reg, ka_zero4_reg, kc_neg4_reg, kc_zero4_reg;
    // stage 5: partial products
    logic [2*HW-1:0]      bhh_reg, bhl_reg, bll_reg;
    logic [2*HW-1:0]      ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    logic [MW-1:0]        ka_mag5_reg;
    logic signed [KW-1:0] kb5_reg;
    logic                 ka_neg5_reg, ka_zero5_reg, kc_neg5_reg, kc_zero5_reg;
    // stage 6: b squared and 4ac
    logic [DW-1:0]        bsq_reg, fac_reg;
    logic [MW-1:0]        ka_mag6_reg;
    logic signed [KW-1:0] kb6_reg;
    logic                 ka_neg6_reg, ka_zero6_reg, kc_neg6_reg, kc_zero6_reg;
    // stage 7: discriminant magnitude
    sq_word_t             out_reg, out_next;

    // Load a stage when it is empty or its word moves on
    always_comb
    begin
        ld[NST] = down_ready;
        for (int k = NST - 1; k >= 0; k--)
            ld[k] = !v_reg[k] || ld[k+1];
    end

    assign up_ready   = ld[0];
    assign down_valid = v_reg[NST-1];
    assign down_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Form A, B, C from the control polygon
    always_comb
    begin
        logic signed [CW-1:0] px, py, qx, qy, rx, ry, sx, sy;
        px = CW'(up_word.start_x);
        py = CW'(up_word.start_y);
        qx = CW'(up_word.ctrl1_x);
        qy = CW'(up_word.ctrl1_y);
        rx = CW'(up_word.ctrl2_x);
        ry = CW'(up_word.ctrl2_y);
        sx = CW'(up_word.end_x);
        sy = CW'(up_word.end_y);
        ax_next = qx - px;
        ay_next = qy - py;
        bx_next = rx - qx - ax_next;
        by_next = ry - qy - ay_next;
        cx_next = sx - rx - ax_next - (bx_next <<< 1);
        cy_next = sy - ry - ay_next - (by_next <<< 1);
    end

    // Pick the discriminant sign and magnitude
    always_comb
    begin
        logic [DW-1:0] sum, d_bf, d_fb;
        logic          add_case, b_ge;
        sum      = bsq_reg + fac_reg;
        d_bf     = bsq_reg - fac_reg;
        d_fb     = fac_reg - bsq_reg;
        add_case = (ka_neg6_reg != kc_neg6_reg) || kc_zero6_reg;
        b_ge     = bsq_reg >= fac_reg;
        out_next.rem    = '0;
        out_next.root   = '0;
        out_next.kb     = kb6_reg;
        out_next.ka_neg = ka_neg6_reg;
        out_next.ka_mag = ka_mag6_reg;
        if (add_case)
        begin
            out_next.rad  = sum;
            out_next.kind = KIND_REAL;
        end
        else if (b_ge)
        begin
            out_next.rad  = d_bf;
            out_next.kind = KIND_REAL;
        end
        else
        begin
            out_next.rad  = d_fb;
            out_next.kind = KIND_COMPLEX;
        end
        if (ka_zero6_reg)
            out_next.kind = KIND_DEGEN;
    end

    // Advance the data stages
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            bx_reg <= bx_next;
            by_reg <= by_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
        if (ld[1])
        begin
            p0_reg <= bx_reg * cy_reg;
            p1_reg <= by_reg * cx_reg;
            p2_reg <= ax_reg * cy_reg;
            p3_reg <= ay_reg * cx_reg;
            p4_reg <= ax_reg * by_reg;
            p5_reg <= ay_reg * bx_reg;
        end
        if (ld[2])
        begin
            ka_reg  <= p0_reg - p1_reg;
            kb3_reg <= p2_reg - p3_reg;
            kc_reg  <= p4_reg - p5_reg;
        end
        if (ld[3])
        begin
            ka_mag4_reg  <= ka_reg[KW-1] ? MW'(-ka_reg) : MW'(ka_reg);
            kb_mag_reg   <= kb3_reg[KW-1] ? MW'(-kb3_reg) : MW'(kb3_reg);
            kc_mag_reg   <= kc_reg[KW-1] ? MW'(-kc_reg) : MW'(kc_reg);
            kb4_reg      <= kb3_reg;
            ka_neg4_reg  <= ka_reg[KW-1];
            ka_zero4_reg <= ka_reg == '0;
            kc_neg4_reg  <= kc_reg[KW-1];
            kc_zero4_reg <= kc_reg == '0;
        end
        if (ld[4])
        begin
            bhh_reg      <= kb_mag_reg[MW-1:HW] * kb_mag_reg[MW-1:HW];
            bhl_reg      <= kb_mag_reg[MW-1:HW] * kb_mag_reg[HW-1:0];
            bll_reg      <= kb_mag_reg[HW-1:0] * kb_mag_reg[HW-1:0];
            ahch_reg     <= ka_mag4_reg[MW-1:HW] * kc_mag_reg[MW-1:HW];
            ahcl_reg     <= ka_mag4_reg[MW-1:HW] * kc_mag_reg[HW-1:0];
            alch_reg     <= ka_mag4_reg[HW-1:0] * kc_mag_reg[MW-1:HW];
            alcl_reg     <= ka_mag4_reg[HW-1:0] * kc_mag_reg[HW-1:0];
            ka_mag5_reg  <= ka_mag4_reg;
            kb5_reg      <= kb4_reg;
            ka_neg5_reg  <= ka_neg4_reg;
            ka_zero5_reg <= ka_zero4_reg;
            kc_neg5_reg  <= kc_neg4_reg;
            kc_zero5_reg <= kc_zero4_reg;
        end
        if (ld[5])
        begin
            bsq_reg <= (DW'(bhh_reg) << (2 * HW)) + (DW'(bhl_reg) << (HW + 1))
                       + DW'(bll_reg);
            fac_reg <= ((DW'(ahch_reg) << (2 * HW))
                       + ((DW'(ahcl_reg) + DW'(alch_reg)) << HW)
                       + DW'(alcl_reg)) << 2;
            ka_mag6_reg  <= ka_mag5_reg;
            kb6_reg      <= kb5_reg;
            ka_neg6_reg  <= ka_neg5_reg;
            ka_zero6_reg <= ka_zero5_reg;
            kc_neg6_reg  <= kc_neg5_reg;
            kc_zero6_reg <= kc_zero5_reg;
        end
        if (ld[6])
            out_reg <= out_next;
    end

endmodule

@@ sv/cbi_sqrt_cell.sv @@
`timescale 1ns / 1ps

module cbi_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  cbi_pkg::sq_word_t up_word,
    output logic              down_valid,
    input  logic              down_ready,
    output cbi_pkg::sq_word_t down_word
);
    import cbi_pkg::*;

    logic     v_reg;
    sq_word_t word_reg, word_next;

    assign up_ready   = !v_reg || down_ready;
    assign down_valid = v_reg;
    assign down_word  = word_reg;

    // Settle one root bit from the next two radicand bits
    always_comb
    begin
        logic [RW-1:0] rem_sh, trial;
        rem_sh = {up_word.rem[RW-3:0], up_word.rad[DW-1:DW-2]};
        trial  = RW'({up_word.root, 2'b01});
        word_next     = up_word;
        word_next.rad = up_word.rad << 2;
        if (rem_sh >= trial)
        begin
            word_next.rem  = rem_sh - trial;
            word_next.root = {up_word.root[SW-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = rem_sh;
            word_next.root = {up_word.root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            word_reg <= word_next;
    end

endmodule

@@ sv/cbi_seed.sv @@
`timescale 1ns / 1ps

module cbi_seed (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cbi_pkg::sq_word_t  up_word,
    output logic               down_valid,
    input  logic               down_ready,
    output cbi_pkg::div_word_t down_word
);
    import cbi_pkg::*;

    logic      v_reg;
    div_word_t word_reg, word_next;

    assign up_ready   = !v_reg || down_ready;
    assign down_valid = v_reg;
    assign down_word  = word_reg;

    // Build the three signed numerators and split them into sign and magnitude
    always_comb
    begin
        logic signed [NSW-1:0] neg_kb, s_ext;
        logic signed [NSW-1:0] n [LANES];
        logic        [NSW-1:0] m;
        neg_kb = -(NSW'(up_word.kb));
        s_ext  = $signed({{(NSW-SW){1'b0}}, up_word.root});
        if (up_word.kind == KIND_COMPLEX)
        begin
            n[0] = neg_kb;
            n[1] = s_ext;
            n[2] = -s_ext;
        end
        else
        begin
            n[0] = neg_kb + s_ext;
            n[1] = neg_kb - s_ext;
            n[2] = '0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            m = n[i][NSW-1] ? $unsigned(-n[i]) : $unsigned(n[i]);
            word_next.num[i] = {m[NMW-1:0], {ROOT_FRAC_BITS{1'b0}}};
            word_next.neg[i] = n[i][NSW-1] ^ up_word.ka_neg;
        end
        word_next.rem  = '0;
        word_next.quo  = '0;
        word_next.ovf  = '0;
        word_next.dv   = {up_word.ka_mag, 1'b0};
        word_next.kind = up_word.kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            word_reg <= word_next;
    end

endmodule

@@ sv/cbi_div_cell.sv @@
`timescale 1ns / 1ps

module cbi_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cbi_pkg::div_word_t up_word,
    output logic               down_valid,
    input  logic               down_ready,
    output cbi_pkg::div_word_t down_word
);
    import cbi_pkg::*;

    logic      v_reg;
    div_word_t word_reg, word_next;

    assign up_ready   = !v_reg || down_ready;
    assign down_valid = v_reg;
    assign down_word  = word_reg;

    // Settle one quotient bit in each lane; remember bits past the top
    always_comb
    begin
        logic [RDW-1:0] rem_sh, dv_ext;
        logic           ge;
        word_next = up_word;
        dv_ext    = RDW'(up_word.dv);
        for (int i = 0; i < LANES; i++)
        begin
            rem_sh = {up_word.rem[i][RDW-2:0], up_word.num[i][NDW-1]};
            ge     = rem_sh >= dv_ext;
            word_next.rem[i] = ge ? rem_sh - dv_ext : rem_sh;
            word_next.quo[i] = {up_word.quo[i][QW-2:0], ge};
            word_next.ovf[i] = up_word.ovf[i] | up_word.quo[i][QW-1];
            word_next.num[i] = up_word.num[i] << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            word_reg <= word_next;
    end

endmodule

@@ sv/cubic_bezier_inflection_solver.sv @@
`timescale 1ns / 1ps

// Cubic Bezier inflection solver.
// Input channel curve/curve_valid/curve_ready takes one word per curve: start,
// two control points and end, signed Q12.4. Output channel roots/roots_valid/
// roots_ready gives one word per curve: both roots of a t^2 + b t + c = 0 in
// Q16.16 (truncated toward zero, saturated) and a kind code: two real roots,
// complex pair, or degenerate (a == 0, all roots zero).
// Throughput: one curve per cycle when the output does not stall. The path from
// accept to roots_valid runs through 7 front stages
// (coefficients, products, cross products, magnitudes, split multiplies,
// sums, discriminant), one cell per root bit of the square root chain,
// one seed stage, one cell per dividend bit of the three-lane divider chain
// and the output register.
// Every stage holds its own valid bit; a stage takes a new word whenever it is
// empty or its word moves on, so bubbles close up and a new curve is taken
// while a finished word waits at the output. When roots_ready stays low the
// chain fills and curve_ready drops once no empty stage is left.
// Reset clears all valid bits; no words are in flight afterward.
module cubic_bezier_inflection_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               curve_valid,
    output logic               curve_ready,
    input  cbi_pkg::in_word_t  curve,
    output logic               roots_valid,
    input  logic               roots_ready,
    output cbi_pkg::out_word_t roots
);
    import cbi_pkg::*;

    logic      sq_v [SW+1];
    logic      sq_r [SW+1];
    sq_word_t  sq_w [SW+1];
    logic      dv_v [NDW+1];
    logic      dv_r [NDW+1];
    div_word_t dv_w [NDW+1];

    logic      out_v_reg;
    out_word_t out_reg, out_next;
    logic      out_ld;

    cbi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (curve_valid),
        .up_ready   (curve_ready),
        .up_word    (curve),
        .down_valid (sq_v[0]),
        .down_ready (sq_r[0]),
        .down_word  (sq_w[0])
    );

    // Square root chain, one root bit per cell
    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        cbi_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (sq_v[i]),
            .up_ready   (sq_r[i]),
            .up_word    (sq_w[i]),
            .down_valid (sq_v[i+1]),
            .down_ready (sq_r[i+1]),
            .down_word  (sq_w[i+1])
        );
    end

    cbi_seed u_seed (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (sq_v[SW]),
        .up_ready   (sq_r[SW]),
        .up_word    (sq_w[SW]),
        .down_valid (dv_v[0]),
        .down_ready (dv_r[0]),
        .down_word  (dv_w[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < NDW; i++)
    begin : g_div
        cbi_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (dv_v[i]),
            .up_ready   (dv_r[i]),
            .up_word    (dv_w[i]),
            .down_valid (dv_v[i+1]),
            .down_ready (dv_r[i+1]),
            .down_word  (dv_w[i+1])
        );
    end

    // Saturate the lanes and place them by root kind
    always_comb
    begin
        logic signed [QW-1:0] l0, l1, l2;
        l0 = sat_root(dv_w[NDW].quo[0], dv_w[NDW].ovf[0], dv_w[NDW].neg[0]);
        l1 = sat_root(dv_w[NDW].quo[1], dv_w[NDW].ovf[1], dv_w[NDW].neg[1]);
        l2 = sat_root(dv_w[NDW].quo[2], dv_w[NDW].ovf[2], dv_w[NDW].neg[2]);
        out_next.root_kind = dv_w[NDW].kind;
        unique case (dv_w[NDW].kind)
            KIND_REAL:
            begin
                out_next.root1_real = l0;
                out_next.root1_imag = '0;
                out_next.root2_real = l1;
                out_next.root2_imag = '0;
            end
            KIND_COMPLEX:
            begin
                out_next.root1_real = l0;
                out_next.root1_imag = l1;
                out_next.root2_real = l0;
                out_next.root2_imag = l2;
            end
            default:
            begin
                out_next.root1_real = '0;
                out_next.root1_imag = '0;
                out_next.root2_real = '0;
                out_next.root2_imag = '0;
            end
        endcase
    end

    // Hold the result word until the receiver takes it
    assign out_ld      = !out_v_reg || roots_ready;
    assign dv_r[NDW]   = out_ld;
    assign roots_valid = out_v_reg;
    assign roots       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_ld)
            out_v_reg <= dv_v[NDW];
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        roots_valid && (roots.root_kind == KIND_DEGEN) |->
            (roots.root1_real == '0) && (roots.root1_imag == '0)
            && (roots.root2_real == '0) && (roots.root2_imag == '0))
        else $error("degenerate word carries nonzero roots");

    a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
        roots_valid && (roots.root_kind == KIND_REAL) |->
            (roots.root1_imag == '0) && (roots.root2_imag == '0))
        else $error("real roots carry imaginary parts");

    a_complex_pair: assert property (@(posedge clk) disable iff (!rst_n)
        roots_valid && (roots.root_kind == KIND_COMPLEX) |->
            roots.root1_real == roots.root2_real)
        else $error("complex pair with differing real parts");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v[NDW] && !out_ld |=> dv_v[NDW] && $stable(dv_w[NDW]))
        else $error("last divider cell changed while output stalled");
`endif

endmodule
